/* rtl/core/fbsm_pkg.sv */
// ----------------------------------------------------------------------------
// fbsm_pkg: shared types and constants
// Request codes, status codes and sizes of the flash block state manager.
// ----------------------------------------------------------------------------
package fbsm_pkg;

  localparam int NUM_BLOCKS_DEF        = 1024;
  localparam int SECTORS_PER_BLOCK_DEF = 256;
  localparam int SECTORS_PER_PAGE_DEF  = 4;
  localparam int NUM_ZONES_DEF         = 8;

  localparam logic [31:0] LSN_ABSENT = 32'hFFFF_FFFF;
  localparam logic [10:0] ZONE_MAX   = 11'd2047;

  localparam logic [10:0] BPZ_RESET     = 11'd128;
  localparam logic [9:0]  RESERVE_RESET = 10'd8;

  localparam logic [0:0] CFG_BPZ     = 1'b0;
  localparam logic [0:0] CFG_RESERVE = 1'b1;

  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_INVAL   = 3'd2;
  localparam logic [2:0] REQ_ERASE   = 3'd3;
  localparam logic [2:0] REQ_ALLOC_L = 3'd4;
  localparam logic [2:0] REQ_ALLOC_M = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_CONFLICT = 3'd2;
  localparam logic [2:0] ST_RESERVE  = 3'd3;
  localparam logic [2:0] ST_NOFREE   = 3'd4;

  // Compare unit operation select
  typedef enum logic [1:0] {
    CMP_LESS,
    CMP_GE,
    CMP_EQ
  } cmp_op_t;

endpackage

/* rtl/core/fbsm_cmp.sv */
// ----------------------------------------------------------------------------
// fbsm_cmp: shared 32-bit compare unit
// One comparator used for wear comparison and logical-number checks.
// ----------------------------------------------------------------------------
module fbsm_cmp (
  input  fbsm_pkg::cmp_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              hit
);

  always_comb begin
    case (op)
      fbsm_pkg::CMP_LESS: hit = (a < b);
      fbsm_pkg::CMP_GE:   hit = (a >= b);
      fbsm_pkg::CMP_EQ:   hit = (a == b);
      default:            hit = 1'b0;
    endcase
  end

endmodule

/* rtl/core/flash_block_state_manager_unit.sv */
// ----------------------------------------------------------------------------
// flash_block_state_manager_unit: NAND block and sector state manager
// Tracks sector and block state and hands out blocks by wear.
// ----------------------------------------------------------------------------
// Usage: raise start with a request on the input ports while busy is low.
// The request is taken at that edge and busy rises. Every request returns
// exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. Configuration writes (cfg_we, cfg_index, cfg_data) must
// be made only while the block is idle; the block does not enforce this.
// Steps: every request passes a fetch and a decode step and ends in a done
// step. A request rejected at decode goes straight to done; invalidate
// checks its sector and then updates it; read has a read and a check step
// per sector of the page; write has a read and a check step per sector of
// the page and then an apply step per sector; erase walks every sector of
// the block to clear it; an allocation walks its zone with a read and a
// check step per block, then a closing step. Busy falls in the cycle that
// shows done, so a new request can be taken at the same edge that takes the
// result; no request is taken before the last one has returned its result.
// The sector and block memories have one registered read port each.
// Reset: after rst the block runs a clearing pass over the sector memories,
// every sector of every block, and over the block tables, with
// busy high; zone free counts load blocks_per_zone as it stands at reset.
// ----------------------------------------------------------------------------
module flash_block_state_manager_unit #(
  parameter int NUM_BLOCKS        = fbsm_pkg::NUM_BLOCKS_DEF,
  parameter int SECTORS_PER_BLOCK = fbsm_pkg::SECTORS_PER_BLOCK_DEF,
  parameter int SECTORS_PER_PAGE  = fbsm_pkg::SECTORS_PER_PAGE_DEF,
  parameter int NUM_ZONES         = fbsm_pkg::NUM_ZONES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [2:0]  req_type,
  input  logic [17:0] sector_address,
  input  logic [9:0]  block_index,
  input  logic [2:0]  zone,
  input  logic        is_gc,
  input  logic [31:0] sector_lsn_0,
  input  logic [31:0] sector_lsn_1,
  input  logic [31:0] sector_lsn_2,
  input  logic [31:0] sector_lsn_3,
  output logic        done,
  output logic [2:0]  status,
  output logic [9:0]  granted_block,
  output logic [2:0]  valid_count,
  output logic [31:0] read_lsn_0,
  output logic [31:0] read_lsn_1,
  output logic [31:0] read_lsn_2,
  output logic [31:0] read_lsn_3
);

  localparam int NSECT = NUM_BLOCKS * SECTORS_PER_BLOCK;
  localparam int SW = $clog2(NSECT);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int IW = $clog2(SECTORS_PER_BLOCK);
  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int FW = $clog2(SECTORS_PER_BLOCK + 1);
  localparam logic [FW-1:0] SPB_F = FW'(SECTORS_PER_BLOCK);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_SECT_RD, S_SECT_CHK, S_WR_APPLY,
    S_INV_APPLY, S_ERASE, S_ALLOC_RD, S_ALLOC_CHK, S_ALLOC_END, S_DONE
  } state_t;

  state_t state;

  logic [10:0] blocks_per_zone;
  logic [9:0]  reserve_blocks;

  // Sector memory: written, valid, logical number in one word.
  logic [33:0] sect_mem [NSECT];
  logic [33:0] sect_q;
  logic        sect_we;
  logic [SW-1:0] sect_wa;
  logic [33:0] sect_wd;
  logic [SW-1:0] sect_ra;

  // Block table: free, erase count, free sectors, invalid sectors.
  logic        blk_free_bits [NUM_BLOCKS];
  logic [31:0] blk_ec_mem [NUM_BLOCKS];
  logic [FW-1:0] blk_fs_mem [NUM_BLOCKS];
  logic [FW-1:0] blk_iv_mem [NUM_BLOCKS];
  logic        free_q;
  logic [31:0] ec_q;
  logic [FW-1:0] fs_q, iv_q;
  logic [BW-1:0] blk_ra;

  logic [10:0] zone_free [NUM_ZONES];

  // Latched request
  logic [2:0]  rq_type;
  logic [17:0] rq_addr;
  logic [9:0]  rq_bidx;
  logic [2:0]  rq_zone;
  logic        rq_gc;
  logic [31:0] rq_lsn [4];

  logic [SW:0] clr_cnt;
  logic [2:0]  k;
  logic [2:0]  cnt;
  logic [BW:0] scan_i, scan_end;
  logic [BW-1:0] best;
  logic [31:0] best_ec;
  logic        found;
  logic [2:0]  res_status;
  logic [31:0] res_lsn [4];

  // Address decode
  logic [17:0] a_blk_w;
  logic [IW-1:0] a_idx;
  logic        a_blk_ok, a_page_ok;
  logic [10:0] zsize;
  logic [BW+11:0] zstart;
  logic [ZW-1:0] zsel;

  assign a_blk_w  = rq_addr >> IW;
  assign a_idx    = rq_addr[IW-1:0];
  assign a_blk_ok = (a_blk_w < 18'(NUM_BLOCKS));
  assign a_page_ok = ((32'(a_idx) % SECTORS_PER_PAGE) == 0) &&
                     (32'(a_idx) + SECTORS_PER_PAGE <= SECTORS_PER_BLOCK);
  assign zsize    = (blocks_per_zone == 11'd0) ? 11'd1 : blocks_per_zone;
  assign zsel     = rq_zone[ZW-1:0];
  assign zstart   = (BW+12)'(rq_zone) * (BW+12)'(zsize);

  logic [BW-1:0] cur_blk;
  assign cur_blk = a_blk_w[BW-1:0];

  // Shared compare unit
  fbsm_pkg::cmp_op_t cmp_op;
  logic [31:0] cmp_a, cmp_b;
  logic cmp_hit;

  fbsm_cmp u_cmp (.op(cmp_op), .a(cmp_a), .b(cmp_b), .hit(cmp_hit));

  always_comb begin
    cmp_op = fbsm_pkg::CMP_EQ;
    cmp_a  = sect_q[31:0];
    cmp_b  = rq_lsn[0];
    if (state == S_ALLOC_CHK) begin
      cmp_op = (rq_type == fbsm_pkg::REQ_ALLOC_M) ? fbsm_pkg::CMP_GE : fbsm_pkg::CMP_LESS;
      cmp_a  = ec_q;
      cmp_b  = best_ec;
    end
  end

  // Sector address of the current page step
  logic [SW-1:0] page_sa;
  assign page_sa = SW'(rq_addr) + SW'(k);

  always_comb begin
    sect_ra = page_sa;
    if (state == S_DECODE && rq_type == fbsm_pkg::REQ_INVAL) sect_ra = SW'(rq_addr);
  end

  always_ff @(posedge clk) begin
    if (sect_we) sect_mem[sect_wa] <= sect_wd;
    sect_q <= sect_mem[sect_ra];
    free_q <= blk_free_bits[blk_ra];
    ec_q <= blk_ec_mem[blk_ra];
    fs_q <= blk_fs_mem[blk_ra];
    iv_q <= blk_iv_mem[blk_ra];
  end

  assign blk_ra = (state inside {S_ALLOC_RD, S_ALLOC_CHK}) ? scan_i[BW-1:0]
                : (rq_type == fbsm_pkg::REQ_ERASE) ? rq_bidx[BW-1:0] : cur_blk;

  // Sector memory write selection
  always_comb begin
    sect_we = 1'b0;
    sect_wa = page_sa;
    sect_wd = {2'b00, fbsm_pkg::LSN_ABSENT};
    case (state)
      S_CLEAR: begin
        sect_we = 1'b1;
        sect_wa = clr_cnt[SW-1:0];
      end
      S_ERASE: begin
        sect_we = 1'b1;
        sect_wa = SW'(rq_bidx[BW-1:0]) * SW'(SECTORS_PER_BLOCK) + SW'(clr_cnt);
      end
      S_WR_APPLY: begin
        sect_we = (rq_lsn[k[1:0]] != fbsm_pkg::LSN_ABSENT);
        sect_wd = {2'b11, rq_lsn[k[1:0]]};
      end
      S_INV_APPLY: begin
        sect_we = 1'b1;
        sect_wa = SW'(rq_addr);
        sect_wd = {2'b10, sect_q[31:0]};
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      blocks_per_zone <= fbsm_pkg::BPZ_RESET;
      reserve_blocks  <= fbsm_pkg::RESERVE_RESET;
      clr_cnt <= '0;
      done <= 1'b0;
      for (int z = 0; z < NUM_ZONES; z++) zone_free[z] <= fbsm_pkg::BPZ_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == fbsm_pkg::CFG_BPZ) blocks_per_zone <= cfg_data;
        else reserve_blocks <= cfg_data[9:0];
      end
      case (state)
        S_CLEAR: begin
          if (clr_cnt < (SW+1)'(NUM_BLOCKS)) begin
            blk_free_bits[clr_cnt[BW-1:0]] <= 1'b1;
            blk_ec_mem[clr_cnt[BW-1:0]] <= '0;
            blk_fs_mem[clr_cnt[BW-1:0]] <= SPB_F;
            blk_iv_mem[clr_cnt[BW-1:0]] <= '0;
          end
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SW+1)'(NSECT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            rq_type <= req_type;
            rq_addr <= sector_address;
            rq_bidx <= block_index;
            rq_zone <= zone;
            rq_gc   <= is_gc;
            rq_lsn[0] <= sector_lsn_0;
            rq_lsn[1] <= sector_lsn_1;
            rq_lsn[2] <= sector_lsn_2;
            rq_lsn[3] <= sector_lsn_3;
            state <= S_FETCH;
          end
        end
        // Waits for the registered block table read of the addressed block's entry.
        S_FETCH: state <= S_DECODE;
        S_DECODE: begin
          k <= '0;
          cnt <= '0;
          found <= 1'b0;
          best <= '0;
          best_ec <= '0;
          clr_cnt <= '0;
          res_status <= fbsm_pkg::ST_OK;
          for (int j = 0; j < 4; j++) res_lsn[j] <= fbsm_pkg::LSN_ABSENT;
          state <= S_DONE;
          case (rq_type)
            fbsm_pkg::REQ_WRITE, fbsm_pkg::REQ_READ: begin
              if (!a_blk_ok || !a_page_ok) res_status <= fbsm_pkg::ST_RANGE;
              else if (free_q) res_status <= fbsm_pkg::ST_CONFLICT;
              else state <= S_SECT_RD;
            end
            fbsm_pkg::REQ_INVAL: begin
              if (!a_blk_ok) res_status <= fbsm_pkg::ST_RANGE;
              else state <= S_SECT_CHK;
            end
            fbsm_pkg::REQ_ERASE: begin
              if (32'(rq_bidx) >= NUM_BLOCKS) res_status <= fbsm_pkg::ST_RANGE;
              else if (free_q)
                res_status <= fbsm_pkg::ST_CONFLICT;
              else state <= S_ERASE;
            end
            fbsm_pkg::REQ_ALLOC_L, fbsm_pkg::REQ_ALLOC_M: begin
              if (32'(rq_zone) >= NUM_ZONES) res_status <= fbsm_pkg::ST_RANGE;
              else if (rq_type == fbsm_pkg::REQ_ALLOC_L && !rq_gc &&
                       zone_free[zsel] <= 11'(reserve_blocks))
                res_status <= fbsm_pkg::ST_RESERVE;
              else begin
                scan_i <= (zstart >= (BW+12)'(NUM_BLOCKS)) ? (BW+1)'(NUM_BLOCKS)
                          : (BW+1)'(zstart);
                scan_end <= (zstart + (BW+12)'(zsize) > (BW+12)'(NUM_BLOCKS))
                            ? (BW+1)'(NUM_BLOCKS) : (BW+1)'(zstart + (BW+12)'(zsize));
                state <= S_ALLOC_RD;
              end
            end
            default: res_status <= fbsm_pkg::ST_RANGE;
          endcase
        end
        S_SECT_RD: state <= (32'(k) == SECTORS_PER_PAGE) ? S_DONE : S_SECT_CHK;
        S_SECT_CHK: begin
          if (rq_type == fbsm_pkg::REQ_INVAL) begin
            if (!sect_q[33] || !sect_q[32] || !cmp_hit) begin
              res_status <= fbsm_pkg::ST_CONFLICT;
              state <= S_DONE;
            end else state <= S_INV_APPLY;
          end else if (rq_type == fbsm_pkg::REQ_READ) begin
            if (sect_q[33] && sect_q[32]) begin
              res_lsn[cnt[1:0]] <= sect_q[31:0];
              cnt <= cnt + 1'b1;
            end
            k <= k + 1'b1;
            state <= (32'(k) + 1 == SECTORS_PER_PAGE) ? S_DONE : S_SECT_RD;
          end else begin
            if (rq_lsn[k[1:0]] != fbsm_pkg::LSN_ABSENT && sect_q[33]) begin
              res_status <= fbsm_pkg::ST_CONFLICT;
              state <= S_DONE;
            end else if (32'(k) + 1 == SECTORS_PER_PAGE) begin
              k <= '0;
              state <= S_WR_APPLY;
            end else begin
              k <= k + 1'b1;
              state <= S_SECT_RD;
            end
          end
        end
        S_WR_APPLY: begin
          if (rq_lsn[k[1:0]] != fbsm_pkg::LSN_ABSENT) cnt <= cnt + 1'b1;
          k <= k + 1'b1;
          if (32'(k) + 1 == SECTORS_PER_PAGE) begin
            blk_fs_mem[cur_blk] <= (fs_q > FW'(cnt) + FW'(rq_lsn[k[1:0]] !=
                                   fbsm_pkg::LSN_ABSENT))
              ? fs_q - FW'(cnt) - FW'(rq_lsn[k[1:0]] != fbsm_pkg::LSN_ABSENT) : '0;
            state <= S_DONE;
          end
        end
        S_INV_APPLY: begin
          if (iv_q < SPB_F) blk_iv_mem[cur_blk] <= iv_q + 1'b1;
          state <= S_DONE;
        end
        S_ERASE: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SW+1)'(SECTORS_PER_BLOCK - 1)) begin
            blk_free_bits[rq_bidx[BW-1:0]] <= 1'b1;
            if (ec_q != 32'hFFFF_FFFF) blk_ec_mem[rq_bidx[BW-1:0]] <= ec_q + 1'b1;
            blk_fs_mem[rq_bidx[BW-1:0]] <= SPB_F;
            blk_iv_mem[rq_bidx[BW-1:0]] <= '0;
            for (int z = 0; z < NUM_ZONES; z++) begin
              if (32'(rq_bidx) >= z * 32'(zsize) && 32'(rq_bidx) < (z + 1) * 32'(zsize) &&
                  zone_free[z] < fbsm_pkg::ZONE_MAX)
                zone_free[z] <= zone_free[z] + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_ALLOC_RD: state <= (scan_i >= scan_end) ? S_ALLOC_END : S_ALLOC_CHK;
        S_ALLOC_CHK: begin
          if (free_q && (!found || cmp_hit)) begin
            found <= 1'b1;
            best <= scan_i[BW-1:0];
            best_ec <= ec_q;
          end
          scan_i <= scan_i + 1'b1;
          state <= S_ALLOC_RD;
        end
        S_ALLOC_END: begin
          if (!found) res_status <= fbsm_pkg::ST_NOFREE;
          else begin
            blk_free_bits[best] <= 1'b0;
            if (zone_free[zsel] != 11'd0) zone_free[zsel] <= zone_free[zsel] - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          status <= res_status;
          granted_block <= (res_status == fbsm_pkg::ST_OK && found) ? 10'(best) : 10'd0;
          valid_count <= (res_status == fbsm_pkg::ST_OK &&
                          (rq_type inside {fbsm_pkg::REQ_WRITE, fbsm_pkg::REQ_READ}))
                         ? cnt : 3'd0;
          read_lsn_0 <= res_lsn[0];
          read_lsn_1 <= res_lsn[1];
          read_lsn_2 <= res_lsn[2];
          read_lsn_3 <= res_lsn[3];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result comes only out of the final step of a request.
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE)) else $error("done without request");
  // A granted block is never reported together with an error status.
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    done && status != fbsm_pkg::ST_OK |-> granted_block == 10'd0)
    else $error("grant with error");
  // Busy is up while a request is in its decode step.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE) |-> busy) else $error("busy low during request");

endmodule
